FILE: rtl/matrix_vector_transform_4x4_top_assert.svh
// Assertion macros, clocked on clk and disabled while rst is high.
`ifndef MATRIX_VECTOR_TRANSFORM_4X4_TOP_ASSERT_SVH
`define MATRIX_VECTOR_TRANSFORM_4X4_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define MVT4_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mvt4 assertion failed");

`define MVT4_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mvt4 assertion failed");

`else

`define MVT4_ASSERT_IMP(label, ante, cons)

`define MVT4_ASSERT_NXT(label, ante, cons)

`endif

`endif

FILE: rtl/mvt4_pkg.sv
package mvt4_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int SLOT_W      = 32;
  localparam int REG_W       = 64;
  localparam int NUM_REGS    = 8;
  localparam int ADDR_W      = 6;
  localparam int DIM         = 4;
  localparam int FRAC_BITS   = 16;

  localparam int PROD_W = 2 * VALUE_WIDTH;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int RND_W  = SUM_W - FRAC_BITS;

  typedef logic [REG_W-1:0] reg_word_t;
  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic signed [SLOT_W-1:0] slot_t;

  // identity matrix in Q16.16
  localparam reg_word_t MAT_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000, 64'h0,
    64'h0001_0000_0000_0000, 64'h0,
    64'h0,                   64'h0000_0000_0001_0000,
    64'h0,                   64'h0001_0000_0000_0000
  };

endpackage

FILE: rtl/mvt4_if.sv
interface mvt4_vec_if;
  import mvt4_pkg::*;

  logic  valid;
  logic  ready;
  slot_t vx;
  slot_t vy;
  slot_t vz;
  slot_t vw;

  modport source(output valid, output vx, output vy, output vz, output vw, input ready);
  modport sink(input valid, input vx, input vy, input vz, input vw, output ready);
endinterface

interface mvt4_res_if;
  import mvt4_pkg::*;

  logic  valid;
  logic  ready;
  slot_t ox;
  slot_t oy;
  slot_t oz;
  slot_t ow;
  logic  saturated;

  modport source(output valid, output ox, output oy, output oz, output ow,
                 output saturated, input ready);
  modport sink(input valid, input ox, input oy, input oz, input ow,
               input saturated, output ready);
endinterface

FILE: rtl/matrix_vector_transform_4x4_top.sv
// Throughput: one vector per cycle while res is not stalled; four register stages
// (input, 16 multipliers, pair sums with rounding offset, final sum with round and
// saturate) lie between vec and res.
// A stall on res holds every stage; bubbles between stages are squeezed out.
// Reset (rst, synchronous): clears all stage valid bits, loads the identity matrix.
`include "matrix_vector_transform_4x4_top_assert.svh"

module matrix_vector_transform_4x4_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mvt4_pkg::ADDR_W-1:0] paddr,
  input  logic [mvt4_pkg::REG_W-1:0]  pwdata,
  output logic [mvt4_pkg::REG_W-1:0]  prdata,
  output logic                      pready,
  mvt4_vec_if.sink                  vec,
  mvt4_res_if.source                res
);
  import mvt4_pkg::*;

  localparam logic signed [PAIR_W-1:0] HALF_LSB = PAIR_W'(1 << (FRAC_BITS - 1));
  localparam logic signed [RND_W-1:0]  RES_MAX  = RND_W'((64'sd1 <<< (VALUE_WIDTH - 1)) - 1);
  localparam logic signed [RND_W-1:0]  RES_MIN  = -RES_MAX - RND_W'(1);
  localparam slot_t OUT_MAX = SLOT_W'(RES_MAX);
  localparam slot_t OUT_MIN = SLOT_W'(RES_MIN);

  // configuration registers
  reg_word_t mat_regs [NUM_REGS];
  logic      cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[ADDR_W-1:3];
  assign prdata  = mat_regs[cfg_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      mat_regs <= MAT_RESET;
    end else if (cfg_wr) begin
      mat_regs[cfg_idx] <= pwdata;
    end
  end

  value_t mat [DIM][DIM];

  always_comb begin
    for (int i = 0; i < DIM; i++) begin
      for (int j = 0; j < DIM; j++) begin
        mat[i][j] = value_t'(mat_regs[2*i + j/2][(j%2)*SLOT_W +: VALUE_WIDTH]);
      end
    end
  end

  // stage valids and enables
  logic v1, v2, v3, rv;
  logic en1, en2, en3, en4;

  assign en4 = !rv || res.ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign vec.ready = en1;

  // stage 1: input register
  value_t vin [DIM];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= vec.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && vec.valid) begin
      vin[0] <= value_t'(vec.vx[VALUE_WIDTH-1:0]);
      vin[1] <= value_t'(vec.vy[VALUE_WIDTH-1:0]);
      vin[2] <= value_t'(vec.vz[VALUE_WIDTH-1:0]);
      vin[3] <= value_t'(vec.vw[VALUE_WIDTH-1:0]);
    end
  end

  // stage 2: element products
  logic signed [PROD_W-1:0] prod [DIM][DIM];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      for (int i = 0; i < DIM; i++) begin
        for (int j = 0; j < DIM; j++) begin
          prod[i][j] <= PROD_W'(mat[i][j]) * PROD_W'(vin[j]);
        end
      end
    end
  end

  // stage 3: pair sums; rounding offset rides on the first pair
  logic signed [PAIR_W-1:0] pair [DIM][2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      for (int i = 0; i < DIM; i++) begin
        pair[i][0] <= PAIR_W'(prod[i][0]) + PAIR_W'(prod[i][1]) + HALF_LSB;
        pair[i][1] <= PAIR_W'(prod[i][2]) + PAIR_W'(prod[i][3]);
      end
    end
  end

  // stage 4: final sum, drop fraction, saturate
  logic signed [SUM_W-1:0] total [DIM];
  logic signed [RND_W-1:0] rnd   [DIM];
  slot_t                   clip  [DIM];
  logic [DIM-1:0]          sat_hit;

  always_comb begin
    for (int i = 0; i < DIM; i++) begin
      total[i] = SUM_W'(pair[i][0]) + SUM_W'(pair[i][1]);
      rnd[i]   = total[i][SUM_W-1:FRAC_BITS];
      if (rnd[i] > RES_MAX) begin
        clip[i]    = OUT_MAX;
        sat_hit[i] = 1'b1;
      end else if (rnd[i] < RES_MIN) begin
        clip[i]    = OUT_MIN;
        sat_hit[i] = 1'b1;
      end else begin
        clip[i]    = SLOT_W'(rnd[i]);
        sat_hit[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
    end else if (en4) begin
      rv <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      res.ox        <= clip[0];
      res.oy        <= clip[1];
      res.oz        <= clip[2];
      res.ow        <= clip[3];
      res.saturated <= |sat_hit;
    end
  end

  assign res.valid = rv;

  `MVT4_ASSERT_NXT(a_accept_fills_s1, vec.valid && vec.ready, v1)
  `MVT4_ASSERT_NXT(a_s1_holds, v1 && !en2, v1 && $stable(vin[0]) && $stable(vin[3]))
  `MVT4_ASSERT_NXT(a_s3_to_out, v3 && en4, res.valid)
  `MVT4_ASSERT_IMP(a_sat_clipped, res.valid && res.saturated,
    res.ox == OUT_MAX || res.ox == OUT_MIN || res.oy == OUT_MAX || res.oy == OUT_MIN ||
    res.oz == OUT_MAX || res.oz == OUT_MIN || res.ow == OUT_MAX || res.ow == OUT_MIN)

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import mvt4_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PIPE_LAT    = 4;
  localparam int REG_STRIDE  = 8;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 105;
  localparam int PRINT_CAP   = 60;

  localparam logic signed [79:0] VAL_MAX = (80'sd1 <<< (VALUE_WIDTH - 1)) - 80'sd1;
  localparam logic signed [79:0] VAL_MIN = -VAL_MAX - 80'sd1;
  localparam logic signed [79:0] HALF_LSB = 80'sd32768;

  localparam slot_t S_MAX  = 32'h7FFF_FFFF;
  localparam slot_t S_MIN  = 32'h8000_0000;
  localparam slot_t S_ONE  = 32'h0001_0000;
  localparam slot_t S_HALF = 32'h0000_8000;

  typedef slot_t [0:DIM-1] vec4_t;

  typedef struct {
    vec4_t comp;
    logic  sat;
  } xform_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  reg_word_t pwdata;
  reg_word_t prdata;
  logic pready;

  mvt4_vec_if vec ();
  mvt4_res_if res ();

  matrix_vector_transform_4x4_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .vec    (vec.sink),
    .res    (res.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  reg_word_t matrix_shadow [NUM_REGS];
  reg_word_t matrix_next [NUM_REGS];
  vec4_t     vec_pending [$];
  xform_t    xform_expected [$];
  string     comp_name [DIM] = '{"ox", "oy", "oz", "ow"};

  int   vectors_queued = 0;
  int   vectors_sent = 0;
  int   mismatches = 0;
  int   cycles = 0;
  int   send_gap = 0;
  int   sink_stall = 0;
  int   send_idle_pct = 0;
  int   sink_idle_pct = 0;
  bit   steady = 1'b0;
  bit   vec_taken = 1'b0;
  vec4_t  vec_next;
  vec4_t  res_got;
  xform_t res_want;

  task automatic log_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < PRINT_CAP)
      $display("mismatch at cycle %0d, %s: got %h, want %h", cycles, what, got, want);
    mismatches++;
  endtask

  function automatic logic signed [79:0] widen(logic [31:0] raw);
    widen = {{(80 - VALUE_WIDTH){raw[VALUE_WIDTH-1]}}, raw[VALUE_WIDTH-1:0]};
  endfunction

  // exact sum of Q32.32 products, round half up to Q16.16, clip to value range
  function automatic xform_t transform_vector(vec4_t v);
    xform_t r;
    logic signed [79:0] acc;
    reg_word_t word;
    logic [31:0] half;
    r.sat = 1'b0;
    for (int i = 0; i < DIM; i++) begin
      acc = '0;
      for (int j = 0; j < DIM; j++) begin
        word = matrix_shadow[i * 2 + j / 2];
        half = (j % 2) ? word[63:32] : word[31:0];
        acc = acc + widen(half) * widen(v[j]);
      end
      acc = (acc + HALF_LSB) >>> FRAC_BITS;
      if (acc > VAL_MAX) begin
        acc = VAL_MAX;
        r.sat = 1'b1;
      end else if (acc < VAL_MIN) begin
        acc = VAL_MIN;
        r.sat = 1'b1;
      end
      r.comp[i] = acc[31:0];
    end
    return r;
  endfunction

  // sampling side: register writes, accepted vectors, result words
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else if (rst) begin
      matrix_shadow = MAT_RESET;
    end else begin
      if (psel && penable && pwrite && pready)
        matrix_shadow[paddr / REG_STRIDE] = pwdata;
      if (vec.valid && vec.ready) begin
        xform_expected.push_back(transform_vector({vec.vx, vec.vy, vec.vz, vec.vw}));
        vectors_sent++;
        vec_taken = 1'b1;
      end
      if (res.valid && res.ready) begin
        if (xform_expected.size() == 0) begin
          log_mismatch("word with nothing pending", res.ox, '0);
        end else begin
          res_want = xform_expected.pop_front();
          res_got = {res.ox, res.oy, res.oz, res.ow};
          for (int k = 0; k < DIM; k++)
            if (res_got[k] !== res_want.comp[k])
              log_mismatch(comp_name[k], res_got[k], res_want.comp[k]);
          if (res.saturated !== res_want.sat)
            log_mismatch("saturated", 32'(res.saturated), 32'(res_want.sat));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      vec.valid <= 1'b0;
    end else if (!vec.valid || vec_taken) begin
      vec_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        vec.valid <= 1'b0;
      end else if (!steady && $urandom_range(99, 0) < send_idle_pct) begin
        send_gap = $urandom_range(18, 0);
        vec.valid <= 1'b0;
      end else if (vec_pending.size() != 0) begin
        vec_next = vec_pending.pop_front();
        vec.vx <= vec_next[0];
        vec.vy <= vec_next[1];
        vec.vz <= vec_next[2];
        vec.vw <= vec_next[3];
        vec.valid <= 1'b1;
      end else begin
        vec.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (sink_stall > 0) begin
      sink_stall--;
      res.ready <= 1'b0;
    end else if (!steady && !rst && $urandom_range(99, 0) < sink_idle_pct) begin
      sink_stall = $urandom_range(18, 0);
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
    end
  end

  task automatic queue_vector(slot_t x, slot_t y, slot_t z, slot_t w);
    vec_pending.push_back({x, y, z, w});
    vectors_queued++;
  endtask

  task automatic wait_all_results();
    while (vectors_sent != vectors_queued || xform_expected.size() != 0)
      @(negedge clk);
    repeat (PIPE_LAT) @(negedge clk);
  endtask

  task automatic write_reg(int idx, reg_word_t data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx * REG_STRIDE);
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_elem(int row, int col, slot_t value);
    if (col % 2)
      matrix_next[row * 2 + col / 2][63:32] = value;
    else
      matrix_next[row * 2 + col / 2][31:0] = value;
  endtask

  task automatic fill_matrix(slot_t value);
    for (int i = 0; i < DIM; i++)
      for (int j = 0; j < DIM; j++)
        set_elem(i, j, value);
  endtask

  task automatic load_matrix();
    for (int k = 0; k < NUM_REGS; k++)
      write_reg(k, matrix_next[k]);
  endtask

  function automatic slot_t rand_value(int style, slot_t span);
    slot_t picks [8] = '{'0, S_ONE, -S_ONE, S_HALF, -S_HALF, S_MAX, S_MIN, 32'hFFFF_FFFF};
    case (style)
      0:       return $urandom;
      1:       return $urandom_range(2 * span, 0) - span;
      default: return picks[$urandom_range(7, 0)];
    endcase
  endfunction

  function automatic int vec_style();
    int r;
    r = $urandom_range(9, 0);
    return (r < 2) ? 0 : (r < 8) ? 1 : 2;
  endfunction

  initial begin
    int mode;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    vec.valid = 1'b0;
    vec.vx = '0;
    vec.vy = '0;
    vec.vz = '0;
    vec.vw = '0;
    res.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 20;
    sink_idle_pct = 20;

    // identity matrix out of reset
    queue_vector('0, '0, '0, '0);
    queue_vector(S_MAX, S_MAX, S_MAX, S_MAX);
    queue_vector(S_MIN, S_MIN, S_MIN, S_MIN);
    queue_vector(32'd1, 32'hFFFF_FFFF, S_ONE, -S_ONE);
    queue_vector(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
    wait_all_results();

    fill_matrix(S_MAX);
    load_matrix();
    queue_vector(S_MAX, S_MAX, S_MAX, S_MAX);
    queue_vector(S_MIN, S_MIN, S_MIN, S_MIN);
    queue_vector('0, '0, '0, '0);
    queue_vector(32'd1, 32'hFFFF_FFFF, '0, '0);
    wait_all_results();

    fill_matrix(S_MIN);
    load_matrix();
    queue_vector(S_MAX, S_MAX, S_MAX, S_MAX);
    queue_vector(S_MIN, S_MIN, S_MIN, S_MIN);
    queue_vector('0, '0, '0, 32'd1);
    wait_all_results();

    // ties: +0.5 and -0.5 lsb both round up
    fill_matrix('0);
    set_elem(0, 0, S_HALF);
    set_elem(1, 0, -S_HALF);
    set_elem(2, 0, S_HALF);
    set_elem(2, 1, S_HALF);
    set_elem(3, 3, S_ONE + S_HALF);
    load_matrix();
    queue_vector(32'd1, '0, '0, '0);
    queue_vector(32'hFFFF_FFFF, '0, '0, '0);
    queue_vector(32'd3, '0, '0, '0);
    queue_vector(32'd1, 32'd1, '0, 32'd1);
    queue_vector('0, '0, '0, 32'hFFFF_FFFF);
    wait_all_results();

    // values at and one lsb beyond both clip points
    fill_matrix('0);
    set_elem(0, 0, S_ONE);
    set_elem(0, 1, S_ONE);
    set_elem(3, 0, -S_ONE);
    set_elem(3, 1, -S_ONE);
    load_matrix();
    queue_vector(S_MAX, 32'd1, '0, '0);
    queue_vector(S_MIN, 32'hFFFF_FFFF, '0, '0);
    queue_vector(S_MAX, '0, '0, '0);
    wait_all_results();

    for (int p = 0; p < RAND_PHASES; p++) begin
      mode = p % 4;
      for (int i = 0; i < DIM; i++)
        for (int j = 0; j < DIM; j++)
          case (mode)
            0: set_elem(i, j, rand_value(1, 32'h2_0000));
            1: set_elem(i, j, rand_value(0, '0));
            2: set_elem(i, j, rand_value($urandom_range(2, 0), 32'h2_0000));
            default: set_elem(i, j, rand_value($urandom_range(2, 1), 32'h2_0000));
          endcase
      load_matrix();
      steady = (p == RAND_PHASES - 1);
      send_idle_pct = $urandom_range(3, 0) * 12;
      sink_idle_pct = $urandom_range(3, 0) * 12;
      for (int n = 0; n < PHASE_ITEMS; n++)
        queue_vector(rand_value(vec_style(), 32'h100_0000),
                     rand_value(vec_style(), 32'h100_0000),
                     rand_value(vec_style(), 32'h100_0000),
                     rand_value(vec_style(), 32'h100_0000));
      wait_all_results();
    end

    repeat (2 * PIPE_LAT) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/mvt4_pkg.sv
rtl/mvt4_if.sv
rtl/matrix_vector_transform_4x4_top.sv
verif/tb_top.sv
